// ===== rtl/core/mrs_pkg.sv =====
`timescale 1ns / 1ps
package mrs_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  EXC_FLAG   = 8'h80;
   localparam logic [7:0]  EXC_CRC    = 8'h08;
   localparam logic [7:0]  EXC_RANGE  = 8'h02;
   localparam logic [7:0]  EXC_FUNC   = 8'h04;
   localparam logic [7:0]  FN_READ_COILS  = 8'h01;
   localparam logic [7:0]  FN_READ_INPUTS = 8'h02;
   localparam logic [7:0]  FN_READ_REGS   = 8'h03;
   localparam logic [7:0]  FN_WRITE_COIL  = 8'h05;
   localparam logic [7:0]  FN_WRITE_REG   = 8'h06;
   localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
   localparam logic [15:0] COIL_ON    = 16'hFF00;
   localparam logic [7:0]  BYTE_MASK  = 8'hFF;

   typedef enum logic [2:0] {
      KIND_EXC,
      KIND_COILS,
      KIND_INPUTS,
      KIND_READ_REGS,
      KIND_WRITE_COIL,
      KIND_WRITE_REG,
      KIND_WRITE_MULTI
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  func;
      logic [7:0]  code;
      logic [15:0] addr;
      logic [15:0] qty;
      logic [15:0] inputs;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MRD_HI,
      ST_MRD_LO,
      ST_MWR,
      ST_EMIT
   } back_state_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/mrs_ram.sv =====
`timescale 1ns / 1ps
module mrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mrs_front.sv =====
`timescale 1ns / 1ps
module mrs_front #(
   parameter int REG_COUNT   = 16,
   parameter int COIL_COUNT  = 32,
   parameter int INPUT_COUNT = 16,
   parameter int FRAME_MAX   = 64,
   localparam int LW = $clog2(FRAME_MAX + 2),
   localparam int AW = $clog2(FRAME_MAX)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_rx_byte,
   input  logic            req_frame_end,
   input  logic [15:0]     req_discrete_inputs,
   input  logic            back_busy,
   input  logic            queue_full,
   output logic            ram_wr_en,
   output logic [AW-1:0]   ram_wr_addr,
   output logic [7:0]      ram_wr_data,
   output logic            push_valid,
   output mrs_pkg::job_type push_job
);

   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    func_ff, func_in, ahi_ff, ahi_in, alo_ff, alo_in;
   logic [7:0]    qhi_ff, qhi_in, qlo_ff, qlo_in, bc_ff, bc_in, last_ff, last_in;
   logic [15:0]   crc_run_ff, crc_run_in, crc_prev_ff, crc_prev_in;
   logic          accept;
   logic [LW-1:0] n_c;
   logic [9:0]    n10;
   logic [7:0]    func_c, bc_c;
   logic [15:0]   a_c, q_c;
   logic [16:0]   sum_c;
   logic          crc_ok, known, cls_push;
   mrs_pkg::kind_type cls_kind;
   logic [7:0]    cls_code;

   assign req_stall = queue_full | back_busy;
   assign accept    = req_valid & ~req_stall;

   // header fields, taking the current byte where it lands on them
   always_comb begin
      func_c = (len_ff == LW'(1)) ? req_rx_byte : func_ff;
      a_c    = {(len_ff == LW'(2)) ? req_rx_byte : ahi_ff,
                (len_ff == LW'(3)) ? req_rx_byte : alo_ff};
      q_c    = {(len_ff == LW'(4)) ? req_rx_byte : qhi_ff,
                (len_ff == LW'(5)) ? req_rx_byte : qlo_ff};
      bc_c   = (len_ff == LW'(6)) ? req_rx_byte : bc_ff;
      n_c    = (len_ff <= LW'(FRAME_MAX)) ? len_ff + LW'(1) : len_ff;
      n10    = 10'(n_c);
      sum_c  = {1'b0, a_c} + {1'b0, q_c};
      crc_ok = (crc_prev_ff[7:0] == last_ff) && (crc_prev_ff[15:8] == req_rx_byte);
   end

   always_comb begin
      known = func_c inside {mrs_pkg::FN_READ_COILS, mrs_pkg::FN_READ_INPUTS,
                             mrs_pkg::FN_READ_REGS, mrs_pkg::FN_WRITE_COIL,
                             mrs_pkg::FN_WRITE_REG, mrs_pkg::FN_WRITE_MULTI};
      cls_push = 1'b1;
      cls_kind = mrs_pkg::KIND_EXC;
      cls_code = mrs_pkg::EXC_RANGE;
      if (n10 < 10'd4 || n10 > 10'(FRAME_MAX)) begin
         cls_push = 1'b0;
      end else if (func_c == mrs_pkg::FN_READ_INPUTS && n10 == 10'd8 && crc_ok &&
                   q_c != 16'd0 && sum_c <= 17'(INPUT_COUNT)) begin
         cls_kind = mrs_pkg::KIND_INPUTS;
      end else if (!crc_ok) begin
         cls_push = known;
         cls_code = mrs_pkg::EXC_CRC;
      end else if (!known) begin
         cls_code = mrs_pkg::EXC_FUNC;
      end else if (func_c != mrs_pkg::FN_WRITE_MULTI && n10 != 10'd8) begin
         cls_code = mrs_pkg::EXC_RANGE;
      end else if (func_c == mrs_pkg::FN_WRITE_MULTI && n10 < 10'd9) begin
         cls_code = mrs_pkg::EXC_RANGE;
      end else begin
         case (func_c)
            mrs_pkg::FN_READ_COILS: begin
               if (q_c != 16'd0 && sum_c <= 17'(COIL_COUNT)) cls_kind = mrs_pkg::KIND_COILS;
            end
            mrs_pkg::FN_READ_INPUTS: begin
               if (q_c != 16'd0 && sum_c <= 17'(INPUT_COUNT)) cls_kind = mrs_pkg::KIND_INPUTS;
            end
            mrs_pkg::FN_READ_REGS: begin
               if (q_c != 16'd0 && sum_c <= 17'(REG_COUNT)) cls_kind = mrs_pkg::KIND_READ_REGS;
            end
            mrs_pkg::FN_WRITE_COIL: begin
               if (a_c < 16'(COIL_COUNT)) cls_kind = mrs_pkg::KIND_WRITE_COIL;
            end
            mrs_pkg::FN_WRITE_REG: begin
               if (a_c < 16'(REG_COUNT)) cls_kind = mrs_pkg::KIND_WRITE_REG;
            end
            mrs_pkg::FN_WRITE_MULTI: begin
               if (q_c != 16'd0 && sum_c <= 17'(REG_COUNT) &&
                   {8'h00, bc_c} == {q_c[14:0], 1'b0} && n10 == 10'd9 + 10'(bc_c))
                  cls_kind = mrs_pkg::KIND_WRITE_MULTI;
            end
            default: cls_code = mrs_pkg::EXC_FUNC;
         endcase
      end
   end

   always_comb begin
      len_in      = len_ff;
      crc_run_in  = crc_run_ff;
      crc_prev_in = crc_prev_ff;
      func_in     = func_ff;
      ahi_in      = ahi_ff;
      alo_in      = alo_ff;
      qhi_in      = qhi_ff;
      qlo_in      = qlo_ff;
      bc_in       = bc_ff;
      last_in     = last_ff;
      if (accept) begin
         func_in = func_c;
         ahi_in  = a_c[15:8];
         alo_in  = a_c[7:0];
         qhi_in  = q_c[15:8];
         qlo_in  = q_c[7:0];
         bc_in   = bc_c;
         last_in = req_rx_byte;
         if (req_frame_end) begin
            len_in      = '0;
            crc_run_in  = mrs_pkg::CRC_INIT;
            crc_prev_in = mrs_pkg::CRC_INIT;
         end else begin
            len_in      = n_c;
            crc_prev_in = crc_run_ff;
            crc_run_in  = mrs_pkg::crc_byte(crc_run_ff, req_rx_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         crc_run_ff  <= mrs_pkg::CRC_INIT;
         crc_prev_ff <= mrs_pkg::CRC_INIT;
      end else begin
         len_ff      <= len_in;
         crc_run_ff  <= crc_run_in;
         crc_prev_ff <= crc_prev_in;
      end
      func_ff <= func_in;
      ahi_ff  <= ahi_in;
      alo_ff  <= alo_in;
      qhi_ff  <= qhi_in;
      qlo_ff  <= qlo_in;
      bc_ff   <= bc_in;
      last_ff <= last_in;
   end

   assign ram_wr_en   = accept && (len_ff < LW'(FRAME_MAX));
   assign ram_wr_addr = len_ff[AW-1:0];
   assign ram_wr_data = req_rx_byte;

   assign push_valid      = accept & req_frame_end & cls_push;
   assign push_job.kind   = cls_kind;
   assign push_job.func   = func_c;
   assign push_job.code   = cls_code;
   assign push_job.addr   = a_c;
   assign push_job.qty    = q_c;
   assign push_job.inputs = 16'(req_discrete_inputs[INPUT_COUNT-1:0]);

endmodule

// ===== rtl/core/mrs_queue.sv =====
`timescale 1ns / 1ps
module mrs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  mrs_pkg::job_type push_job,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mrs_pkg::job_type pop_job
);

   logic             valid_ff, valid_in;
   mrs_pkg::job_type job_ff, job_in;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (pop_ready) valid_in = 1'b0;
      if (push_valid) begin
         valid_in = 1'b1;
         job_in   = push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign full      = valid_ff;
   assign pop_valid = valid_ff;
   assign pop_job   = job_ff;

endmodule

// ===== rtl/core/mrs_back.sv =====
`timescale 1ns / 1ps
module mrs_back #(
   parameter int REG_COUNT  = 16,
   parameter int COIL_COUNT = 32,
   parameter int FRAME_MAX  = 64,
   localparam int AW = $clog2(FRAME_MAX),
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1,
   localparam int CW = $clog2(COIL_COUNT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       station_address,
   input  logic             job_valid,
   output logic             job_pop,
   input  mrs_pkg::job_type job,
   output logic             busy,
   output logic [AW-1:0]    ram_rd_addr,
   input  logic [7:0]       ram_rd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_reply_last,
   output logic [31:0]      rsp_coil_levels
);

   mrs_pkg::back_state_type state_ff, state_in;
   mrs_pkg::job_type job_ff, job_in;
   logic [COIL_COUNT-1:0] coil_ff, coil_in;
   logic [15:0]   hold_ff [REG_COUNT];
   logic          hw_en;
   logic [RW-1:0] hw_addr;
   logic [15:0]   hw_data;
   logic [31:0]   bits_ff, bits_in, src;
   logic [RW-1:0] ptr_ff, ptr_in;
   logic          lo_ff, lo_in;
   logic [6:0]    idx_ff, idx_in, blen_ff, blen_in;
   logic [15:0]   crc_ff, crc_in;
   logic [AW-1:0] radr_ff, radr_in;
   logic [7:0]    hi_ff, hi_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          ov_ff, ov_in, olast_ff, olast_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic [31:0]   ocoil_ff, ocoil_in;
   logic          out_load;
   logic [7:0]    body;
   logic [6:0]    nbytes;

   assign out_load = ~ov_ff | ~rsp_stall;
   assign busy     = (state_ff != mrs_pkg::ST_IDLE);
   assign ram_rd_addr = radr_ff;
   assign nbytes   = (7'(job_ff.qty[5:0]) + 7'd7) >> 3;
   assign src      = (job_ff.kind == mrs_pkg::KIND_COILS) ? 32'(coil_ff) : 32'(job_ff.inputs);

   // body byte at the current position
   always_comb begin
      body = 8'h00;
      if (idx_ff == 7'd0) begin
         body = station_address;
      end else if (idx_ff == 7'd1) begin
         body = (job_ff.kind == mrs_pkg::KIND_EXC) ? (job_ff.func | mrs_pkg::EXC_FLAG)
                                                   : job_ff.func;
      end else if (idx_ff == 7'd2) begin
         case (job_ff.kind)
            mrs_pkg::KIND_EXC:                          body = job_ff.code;
            mrs_pkg::KIND_COILS, mrs_pkg::KIND_INPUTS:  body = 8'(nbytes);
            mrs_pkg::KIND_READ_REGS:                    body = {job_ff.qty[6:0], 1'b0};
            default:                                    body = job_ff.addr[15:8];
         endcase
      end else begin
         case (job_ff.kind)
            mrs_pkg::KIND_COILS, mrs_pkg::KIND_INPUTS: body = bits_ff[7:0];
            mrs_pkg::KIND_READ_REGS:
               body = lo_ff ? hold_ff[ptr_ff][7:0] : hold_ff[ptr_ff][15:8];
            default: begin
               if (idx_ff == 7'd3)      body = job_ff.addr[7:0];
               else if (idx_ff == 7'd4) body = job_ff.qty[15:8];
               else                     body = job_ff.qty[7:0];
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      coil_in  = coil_ff;
      bits_in  = bits_ff;
      ptr_in   = ptr_ff;
      lo_in    = lo_ff;
      idx_in   = idx_ff;
      blen_in  = blen_ff;
      crc_in   = crc_ff;
      radr_in  = radr_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff;
      olast_in = olast_ff;
      obyte_in = obyte_ff;
      ocoil_in = ocoil_ff;
      job_pop  = 1'b0;
      hw_en    = 1'b0;
      hw_addr  = job_ff.addr[RW-1:0];
      hw_data  = job_ff.qty;
      if (out_load) ov_in = 1'b0;
      case (state_ff)
         mrs_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = mrs_pkg::ST_EXEC;
            end
         end
         mrs_pkg::ST_EXEC: begin
            idx_in   = '0;
            crc_in   = mrs_pkg::CRC_INIT;
            lo_in    = 1'b0;
            ptr_in   = job_ff.addr[RW-1:0];
            bits_in  = (src >> job_ff.addr[4:0]) & ~(32'hFFFF_FFFF << job_ff.qty[5:0]);
            radr_in  = AW'(7);
            cnt_in   = '0;
            state_in = mrs_pkg::ST_EMIT;
            case (job_ff.kind)
               mrs_pkg::KIND_EXC:                         blen_in = 7'd3;
               mrs_pkg::KIND_COILS, mrs_pkg::KIND_INPUTS: blen_in = 7'd3 + nbytes;
               mrs_pkg::KIND_READ_REGS:  blen_in = 7'd3 + {job_ff.qty[5:0], 1'b0};
               default:                                   blen_in = 7'd6;
            endcase
            if (job_ff.kind == mrs_pkg::KIND_WRITE_COIL) begin
               if (job_ff.qty == mrs_pkg::COIL_ON)
                  coil_in[job_ff.addr[CW-1:0]] = 1'b1;
               else if (job_ff.qty == 16'h0000)
                  coil_in[job_ff.addr[CW-1:0]] = 1'b0;
            end
            if (job_ff.kind == mrs_pkg::KIND_WRITE_REG) hw_en = 1'b1;
            if (job_ff.kind == mrs_pkg::KIND_WRITE_MULTI) state_in = mrs_pkg::ST_MRD_HI;
         end
         mrs_pkg::ST_MRD_HI: begin
            radr_in  = radr_ff + AW'(1);
            state_in = mrs_pkg::ST_MRD_LO;
         end
         mrs_pkg::ST_MRD_LO: begin
            hi_in    = ram_rd_data;
            radr_in  = radr_ff + AW'(1);
            state_in = mrs_pkg::ST_MWR;
         end
         mrs_pkg::ST_MWR: begin
            hw_en   = 1'b1;
            hw_addr = ptr_ff;
            hw_data = {hi_ff, ram_rd_data};
            ptr_in  = ptr_ff + RW'(1);
            cnt_in  = cnt_ff + 5'd1;
            if (16'(cnt_ff) + 16'd1 == job_ff.qty) begin
               state_in = mrs_pkg::ST_EMIT;
               ptr_in   = job_ff.addr[RW-1:0];
            end else begin
               state_in = mrs_pkg::ST_MRD_HI;
            end
         end
         mrs_pkg::ST_EMIT: begin
            if (out_load) begin
               ov_in    = 1'b1;
               ocoil_in = 32'(coil_ff);
               olast_in = 1'b0;
               idx_in   = idx_ff + 7'd1;
               if (idx_ff < blen_ff) begin
                  obyte_in = body;
                  crc_in   = mrs_pkg::crc_byte(crc_ff, body);
                  if (idx_ff >= 7'd3) begin
                     bits_in = bits_ff >> 8;
                     lo_in   = ~lo_ff;
                     if (lo_ff) ptr_in = ptr_ff + RW'(1);
                  end
               end else if (idx_ff == blen_ff) begin
                  obyte_in = crc_ff[7:0];
               end else begin
                  obyte_in = crc_ff[15:8];
                  olast_in = 1'b1;
                  state_in = mrs_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mrs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrs_pkg::ST_IDLE;
         coil_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         coil_ff  <= coil_in;
         ov_ff    <= ov_in;
      end
      job_ff   <= job_in;
      bits_ff  <= bits_in;
      ptr_ff   <= ptr_in;
      lo_ff    <= lo_in;
      idx_ff   <= idx_in;
      blen_ff  <= blen_in;
      crc_ff   <= crc_in;
      radr_ff  <= radr_in;
      hi_ff    <= hi_in;
      cnt_ff   <= cnt_in;
      olast_ff <= olast_in;
      obyte_ff <= obyte_in;
      ocoil_ff <= ocoil_in;
   end

   // holding registers power up as one for the low twenty words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            hold_ff[i] <= (i < 20) ? 16'd1 : 16'd0;
         end
      end else if (hw_en) begin
         hold_ff[hw_addr] <= hw_data;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_tx_byte     = obyte_ff;
   assign rsp_reply_last  = olast_ff;
   assign rsp_coil_levels = ocoil_ff;

endmodule

// ===== rtl/core/modbus_rtu_slave_frame_handler_top.sv =====
`timescale 1ns / 1ps
// modbus rtu slave frame handler
// req channel: one received byte per beat, req_frame_end on the last byte of
//   the frame, req_discrete_inputs sampled on that last beat
// rsp channel: one reply byte per beat, rsp_reply_last on the crc high byte,
//   rsp_coil_levels gives the coils after the request on every beat
// csr channel: write of the station address, always ready, reset value 4
// a byte that does not end a frame goes into the frame memory; after the
//   last byte the job is registered in the queue and the sequencer takes it
//   (write multiple first reads each register from the frame memory), then
//   sends one reply byte per cycle while rsp is not stalled
// the front side stalls req while a frame is queued or being served, so one
//   frame is handled at a time; rsp stall holds the reply byte in the output
//   register and the reply sequencer waits
// reset clears the frame counter, coils, queue and output; holding words
//   take their power-up value at once, no clearing pass is needed
module modbus_rtu_slave_frame_handler_top #(
   parameter int REG_COUNT   = 16,
   parameter int COIL_COUNT  = 32,
   parameter int INPUT_COUNT = 16,
   parameter int FRAME_MAX   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   input  logic [15:0] req_discrete_inputs,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_reply_last,
   output logic [31:0] rsp_coil_levels,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_station_address
);

   localparam int AW = $clog2(FRAME_MAX);

   logic [7:0]       station_ff, station_in;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;
   logic             push_valid, queue_full, pop_valid, pop_ready, back_busy;
   mrs_pkg::job_type push_job, pop_job;

   assign csr_ready  = 1'b1;
   assign station_in = (csr_valid & csr_ready) ? csr_station_address : station_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= 8'd4;
      end else begin
         station_ff <= station_in;
      end
   end

   mrs_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mrs_front #(
      .REG_COUNT(REG_COUNT), .COIL_COUNT(COIL_COUNT),
      .INPUT_COUNT(INPUT_COUNT), .FRAME_MAX(FRAME_MAX)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .req_frame_end       (req_frame_end),
      .req_discrete_inputs (req_discrete_inputs),
      .back_busy           (back_busy),
      .queue_full          (queue_full),
      .ram_wr_en           (ram_wr_en),
      .ram_wr_addr         (ram_wr_addr),
      .ram_wr_data         (ram_wr_data),
      .push_valid          (push_valid),
      .push_job            (push_job)
   );

   mrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   mrs_back #(
      .REG_COUNT(REG_COUNT), .COIL_COUNT(COIL_COUNT), .FRAME_MAX(FRAME_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .station_address (station_ff),
      .job_valid       (pop_valid),
      .job_pop         (pop_ready),
      .job             (pop_job),
      .busy            (back_busy),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_reply_last  (rsp_reply_last),
      .rsp_coil_levels (rsp_coil_levels)
   );

endmodule
